/* rtl/lod_pkg.sv */
// shared types and constants for the label overlap detection block
// no dependencies
`default_nettype none

package lod_pkg;

   localparam int LABEL_WIDTH     = 6;
   localparam int OUT_COUNT_WIDTH = 24;
   localparam int THR_WIDTH       = 17;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int Q_SHIFT         = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAMMA = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BETA  = 2'd2;

   localparam logic [THR_WIDTH-1:0] ALPHA_RESET = 17'd6554;
   localparam logic [THR_WIDTH-1:0] GAMMA_RESET = 17'd42598;
   localparam logic [THR_WIDTH-1:0] BETA_RESET  = 17'd45875;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [LABEL_WIDTH-1:0] ref_label;
      logic [LABEL_WIDTH-1:0] test_label;
   } req_word_type;

   typedef struct packed {
      logic [LABEL_WIDTH-1:0]     object_index;
      logic [OUT_COUNT_WIDTH-1:0] voxel_count;
      logic                       detected;
      logic                       last;
   } rsp_word_type;

endpackage

`default_nettype wire

/* rtl/lod_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/lod_eval.sv */
// evaluation sequencer: per reference object threshold tests and ordered walk
// depends on lod_pkg; reads the overlap, row and column memories of the top level
`default_nettype none

module lod_eval
   import lod_pkg::*;
#(
   parameter int MAX_REF_LABELS  = 64,
   parameter int MAX_TEST_LABELS = 64,
   parameter int COUNT_WIDTH     = 24
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire logic                                               go,
   input  wire logic [LABEL_WIDTH-1:0]                             hr,
   input  wire logic [LABEL_WIDTH-1:0]                             ht,
   input  wire logic [THR_WIDTH-1:0]                               alpha,
   input  wire logic [THR_WIDTH-1:0]                               gamma,
   input  wire logic [THR_WIDTH-1:0]                               beta,
   input  wire logic [COUNT_WIDTH-1:0]                             ovl_rdata,
   input  wire logic [COUNT_WIDTH-1:0]                             row_rdata,
   input  wire logic [COUNT_WIDTH-1:0]                             col_rdata,
   output logic      [$clog2(MAX_REF_LABELS*MAX_TEST_LABELS)-1:0] ovl_addr,
   output logic      [$clog2(MAX_REF_LABELS)-1:0]                  row_addr,
   output logic      [$clog2(MAX_TEST_LABELS)-1:0]                 col_addr,
   output logic                                                    rsp_strobe,
   output rsp_word_type                                            rsp_word,
   output logic                                                    done
);

   localparam int OA = $clog2(MAX_REF_LABELS*MAX_TEST_LABELS);
   localparam int RA = $clog2(MAX_REF_LABELS);
   localparam int TA = $clog2(MAX_TEST_LABELS);
   localparam int DW = COUNT_WIDTH + 1;
   localparam int AW = COUNT_WIDTH + 6;
   localparam int PW = COUNT_WIDTH + 24;
   localparam int CAP_BITS = (COUNT_WIDTH < OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;
   localparam logic [DW-1:0] CAP = DW'((64'd1 << CAP_BITS) - 64'd1);

   typedef enum logic [3:0] {
      IDLE, NONE, ROW_RD, ROW_DAT, ALPHA_MUL, ALPHA_CMP, STEP, SCAN, SCAN_END,
      SCAN_DEC, VETO_RD, VETO_DAT, VETO_MUL, VETO_CMP, EMIT, DONE
   } eval_state_type;

   eval_state_type state_ff;

   logic [LABEL_WIDTH-1:0] idx_ff, hr_ff, ht_ff, scan_t_ff, rd_t_ff;
   logic [LABEL_WIDTH-1:0] prev_t_ff, best_t_ff;
   logic [DW-1:0]          denom_ff, sum_ff;
   logic [COUNT_WIDTH-1:0] row_ff, prev_v_ff, best_v_ff, o0_ff;
   logic [PW-1:0]          aprod_ff, gprod_ff, bprod_ff;
   logic [AW-1:0]          acc_ff;
   logic                   have_prev_ff, best_valid_ff, rd_valid_ff, det_ff;
   logic                   rsp_strobe_ff, done_ff;
   rsp_word_type           rsp_word_ff;

   logic [THR_WIDTH+DW-1:0]          amul, bmul;
   logic [THR_WIDTH+COUNT_WIDTH-1:0] gmul;
   logic                             elig, take;
   logic [DW-1:0]                    vox;

   function automatic logic [OA-1:0] cell_addr(input logic [LABEL_WIDTH-1:0] r,
                                                input logic [LABEL_WIDTH-1:0] t);
      cell_addr = OA'(int'(r) * MAX_TEST_LABELS + int'(t));
   endfunction

   always_comb begin
      amul = THR_WIDTH'(alpha) * denom_ff;
      gmul = THR_WIDTH'(gamma) * row_ff;
      bmul = THR_WIDTH'(beta) * sum_ff;
      elig = !have_prev_ff || (ovl_rdata < prev_v_ff) ||
             ((ovl_rdata == prev_v_ff) && (rd_t_ff > prev_t_ff));
      take = rd_valid_ff && elig && (!best_valid_ff || (ovl_rdata > best_v_ff));
      vox  = (denom_ff > CAP) ? CAP : denom_ff;
      row_addr = RA'(idx_ff);
      col_addr = TA'(best_t_ff);
      case (state_ff)
         SCAN:    ovl_addr = cell_addr(idx_ff, scan_t_ff);
         VETO_RD: ovl_addr = cell_addr('0, best_t_ff);
         default: ovl_addr = cell_addr(idx_ff, '0);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_strobe_ff <= 1'b0;
         done_ff       <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         done_ff       <= 1'b0;
         rd_valid_ff   <= (state_ff == SCAN);
         rd_t_ff       <= scan_t_ff;
         if (take) begin
            best_valid_ff <= 1'b1;
            best_v_ff     <= ovl_rdata;
            best_t_ff     <= rd_t_ff;
         end
         unique case (state_ff)
            IDLE: begin
               if (go) begin
                  hr_ff    <= hr;
                  ht_ff    <= ht;
                  idx_ff   <= LABEL_WIDTH'(1);
                  state_ff <= (hr == '0) ? NONE : ROW_RD;
               end
            end
            NONE: begin
               rsp_strobe_ff <= 1'b1;
               rsp_word_ff   <= '{object_index: '0, voxel_count: '0, detected: 1'b0,
                                  last: 1'b1};
               state_ff      <= DONE;
            end
            ROW_RD: state_ff <= ROW_DAT;
            ROW_DAT: begin
               denom_ff <= DW'(ovl_rdata) + DW'(row_rdata);
               row_ff   <= row_rdata;
               state_ff <= ALPHA_MUL;
            end
            ALPHA_MUL: begin
               aprod_ff <= PW'(amul);
               gprod_ff <= PW'(gmul);
               state_ff <= ALPHA_CMP;
            end
            ALPHA_CMP: begin
               if ((PW'(row_ff) << Q_SHIFT) <= aprod_ff) begin
                  det_ff   <= 1'b0;
                  state_ff <= EMIT;
               end else begin
                  acc_ff       <= '0;
                  have_prev_ff <= 1'b0;
                  state_ff     <= STEP;
               end
            end
            STEP: begin
               best_valid_ff <= 1'b0;
               scan_t_ff     <= LABEL_WIDTH'(1);
               if (!((PW'(acc_ff) << Q_SHIFT) < gprod_ff) || (ht_ff == '0)) begin
                  det_ff   <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               scan_t_ff <= scan_t_ff + LABEL_WIDTH'(1);
               if (scan_t_ff == ht_ff) begin
                  state_ff <= SCAN_END;
               end
            end
            SCAN_END: state_ff <= SCAN_DEC;
            SCAN_DEC: begin
               if (!best_valid_ff) begin
                  det_ff   <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= VETO_RD;
               end
            end
            VETO_RD: state_ff <= VETO_DAT;
            VETO_DAT: begin
               o0_ff    <= ovl_rdata;
               sum_ff   <= DW'(ovl_rdata) + DW'(col_rdata);
               state_ff <= VETO_MUL;
            end
            VETO_MUL: begin
               bprod_ff <= PW'(bmul);
               state_ff <= VETO_CMP;
            end
            VETO_CMP: begin
               if ((PW'(o0_ff) << Q_SHIFT) > bprod_ff) begin
                  det_ff   <= 1'b0;
                  state_ff <= EMIT;
               end else begin
                  acc_ff       <= acc_ff + AW'(best_v_ff);
                  prev_v_ff    <= best_v_ff;
                  prev_t_ff    <= best_t_ff;
                  have_prev_ff <= 1'b1;
                  state_ff     <= STEP;
               end
            end
            EMIT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_word_ff   <= '{object_index: idx_ff,
                                  voxel_count: OUT_COUNT_WIDTH'(vox),
                                  detected: det_ff, last: (idx_ff == hr_ff)};
               if (idx_ff == hr_ff) begin
                  state_ff <= DONE;
               end else begin
                  idx_ff   <= idx_ff + LABEL_WIDTH'(1);
                  state_ff <= ROW_RD;
               end
            end
            DONE: begin
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;
   assign done       = done_ff;

`ifndef SYNTHESIS
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> (scan_t_ff <= ht_ff) && (scan_t_ff != '0))
      else $error("scan label out of range");
   a_emit_then_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |=> rsp_strobe_ff)
      else $error("emit without strobe");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(rsp_strobe_ff) && $past(rsp_word_ff.last))
      else $error("done without last word");
`endif

endmodule

`default_nettype wire

/* rtl/label_overlap_detection.sv */
// top level: command port, configuration registers, accumulate read-modify-write pipeline, clear sweep
// depends on lod_pkg, lod_ram and lod_eval
`default_nettype none

// An accumulate word is taken every cycle while busy is low; the overlap
// count, row total and column total memories are updated by a registered
// read and then a write, with forwarding, so back-to-back hits on one cell
// count correctly. An evaluate word raises busy until the whole evaluation
// and clear are over. Per reference object the row total is read and the
// minimum overlap test made; an object that passes walks test objects, and
// every step scans one row through the single read port of the overlap
// memory. After the last result the memories are swept clear, one cell per
// cycle over all MAX_REF_LABELS * MAX_TEST_LABELS cells (4096 by default);
// the same sweep runs after reset. Results come out one per strobe and
// cannot be held off. Configuration writes are always ready.
module label_overlap_detection
   import lod_pkg::*;
#(
   parameter int MAX_REF_LABELS  = 64,
   parameter int MAX_TEST_LABELS = 64,
   parameter int COUNT_WIDTH     = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire req_word_type               req_word,
   output logic                            rsp_strobe,
   output rsp_word_type                    rsp_word,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [THR_WIDTH-1:0]       csr_data
);

   localparam int DEPTH = MAX_REF_LABELS * MAX_TEST_LABELS;
   localparam int OA    = $clog2(DEPTH);
   localparam int RA    = $clog2(MAX_REF_LABELS);
   localparam int TA    = $clog2(MAX_TEST_LABELS);
   localparam int CW    = COUNT_WIDTH;

   typedef enum logic [1:0] {T_CLEAR, T_RUN, T_EVAL} top_state_type;

   top_state_type state_ff;

   logic [OA-1:0]          clr_cnt_ff;
   logic [LABEL_WIDTH-1:0] hr_ff, ht_ff;
   logic [THR_WIDTH-1:0]   alpha_ff, gamma_ff, beta_ff;
   logic                   eval_go_ff;

   logic          s1_valid_ff, s1_both_ff;
   logic [OA-1:0] s1_oaddr_ff;
   logic [RA-1:0] s1_raddr_ff;
   logic [TA-1:0] s1_caddr_ff;

   logic          fo_valid_ff, fr_valid_ff, fc_valid_ff;
   logic [OA-1:0] fo_addr_ff;
   logic [RA-1:0] fr_addr_ff;
   logic [TA-1:0] fc_addr_ff;
   logic [CW-1:0] fo_data_ff, fr_data_ff, fc_data_ff;

   logic          accept, in_range, is_accum;
   logic [OA-1:0] ovl_raddr, ovl_waddr, ev_ovl_addr, req_oaddr;
   logic [RA-1:0] row_raddr, row_waddr, ev_row_addr, req_raddr;
   logic [TA-1:0] col_raddr, col_waddr, ev_col_addr, req_caddr;
   logic [CW-1:0] ovl_rdata, row_rdata, col_rdata;
   logic [CW-1:0] o_cur, r_cur, c_cur, o_new, r_new, c_new;
   logic [CW-1:0] ovl_wdata, row_wdata, col_wdata;
   logic          ovl_we, row_we, col_we, ev_done;

   assign busy      = (state_ff != T_RUN);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign in_range  = (32'(req_word.ref_label) < MAX_REF_LABELS) &&
                      (32'(req_word.test_label) < MAX_TEST_LABELS);
   assign is_accum  = accept && (req_word.op == OP_ACCUM) && in_range;
   assign req_oaddr = OA'(int'(req_word.ref_label) * MAX_TEST_LABELS +
                          int'(req_word.test_label));
   assign req_raddr = RA'(req_word.ref_label);
   assign req_caddr = TA'(req_word.test_label);

   always_comb begin
      if (state_ff == T_EVAL) begin
         ovl_raddr = ev_ovl_addr;
         row_raddr = ev_row_addr;
         col_raddr = ev_col_addr;
      end else begin
         ovl_raddr = req_oaddr;
         row_raddr = req_raddr;
         col_raddr = req_caddr;
      end
      o_cur = (fo_valid_ff && (fo_addr_ff == s1_oaddr_ff)) ? fo_data_ff : ovl_rdata;
      r_cur = (fr_valid_ff && (fr_addr_ff == s1_raddr_ff)) ? fr_data_ff : row_rdata;
      c_cur = (fc_valid_ff && (fc_addr_ff == s1_caddr_ff)) ? fc_data_ff : col_rdata;
      o_new = (&o_cur) ? o_cur : o_cur + CW'(1);
      r_new = (&r_cur) ? r_cur : r_cur + CW'(1);
      c_new = (&c_cur) ? c_cur : c_cur + CW'(1);
      if (state_ff == T_CLEAR) begin
         ovl_we    = 1'b1;
         row_we    = (32'(clr_cnt_ff) < MAX_REF_LABELS);
         col_we    = (32'(clr_cnt_ff) < MAX_TEST_LABELS);
         ovl_waddr = clr_cnt_ff;
         row_waddr = RA'(clr_cnt_ff);
         col_waddr = TA'(clr_cnt_ff);
         ovl_wdata = '0;
         row_wdata = '0;
         col_wdata = '0;
      end else begin
         ovl_we    = s1_valid_ff;
         row_we    = s1_valid_ff && s1_both_ff;
         col_we    = s1_valid_ff && s1_both_ff;
         ovl_waddr = s1_oaddr_ff;
         row_waddr = s1_raddr_ff;
         col_waddr = s1_caddr_ff;
         ovl_wdata = o_new;
         row_wdata = r_new;
         col_wdata = c_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_CLEAR;
         clr_cnt_ff  <= '0;
         hr_ff       <= '0;
         ht_ff       <= '0;
         eval_go_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         fo_valid_ff <= 1'b0;
         fr_valid_ff <= 1'b0;
         fc_valid_ff <= 1'b0;
         alpha_ff    <= ALPHA_RESET;
         gamma_ff    <= GAMMA_RESET;
         beta_ff     <= BETA_RESET;
      end else begin
         eval_go_ff  <= 1'b0;
         s1_valid_ff <= is_accum;
         fo_valid_ff <= (state_ff != T_CLEAR) && s1_valid_ff;
         fr_valid_ff <= (state_ff != T_CLEAR) && s1_valid_ff && s1_both_ff;
         fc_valid_ff <= (state_ff != T_CLEAR) && s1_valid_ff && s1_both_ff;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ALPHA: alpha_ff <= csr_data;
               CSR_GAMMA: gamma_ff <= csr_data;
               CSR_BETA:  beta_ff  <= csr_data;
               default: ;
            endcase
         end
         if (is_accum) begin
            if (req_word.ref_label > hr_ff) begin
               hr_ff <= req_word.ref_label;
            end
            if (req_word.test_label > ht_ff) begin
               ht_ff <= req_word.test_label;
            end
         end
         unique case (state_ff)
            T_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + OA'(1);
               if (clr_cnt_ff == OA'(DEPTH - 1)) begin
                  state_ff <= T_RUN;
               end
            end
            T_RUN: begin
               if (accept && (req_word.op == OP_EVAL)) begin
                  eval_go_ff <= 1'b1;
                  state_ff   <= T_EVAL;
               end
            end
            T_EVAL: begin
               if (ev_done) begin
                  clr_cnt_ff <= '0;
                  hr_ff      <= '0;
                  ht_ff      <= '0;
                  state_ff   <= T_CLEAR;
               end
            end
            default: state_ff <= T_CLEAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s1_oaddr_ff <= req_oaddr;
      s1_raddr_ff <= req_raddr;
      s1_caddr_ff <= req_caddr;
      s1_both_ff  <= (req_word.ref_label != '0) && (req_word.test_label != '0);
      fo_addr_ff  <= s1_oaddr_ff;
      fr_addr_ff  <= s1_raddr_ff;
      fc_addr_ff  <= s1_caddr_ff;
      fo_data_ff  <= o_new;
      fr_data_ff  <= r_new;
      fc_data_ff  <= c_new;
   end

   lod_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ovl_ram (
      .clock   (clock),
      .wr_en   (ovl_we),
      .wr_addr (ovl_waddr),
      .wr_data (ovl_wdata),
      .rd_addr (ovl_raddr),
      .rd_data (ovl_rdata)
   );

   lod_ram #(.WIDTH(CW), .DEPTH(MAX_REF_LABELS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   lod_ram #(.WIDTH(CW), .DEPTH(MAX_TEST_LABELS)) u_col_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_addr (col_raddr),
      .rd_data (col_rdata)
   );

   lod_eval #(
      .MAX_REF_LABELS  (MAX_REF_LABELS),
      .MAX_TEST_LABELS (MAX_TEST_LABELS),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .go         (eval_go_ff),
      .hr         (hr_ff),
      .ht         (ht_ff),
      .alpha      (alpha_ff),
      .gamma      (gamma_ff),
      .beta       (beta_ff),
      .ovl_rdata  (ovl_rdata),
      .row_rdata  (row_rdata),
      .col_rdata  (col_rdata),
      .ovl_addr   (ev_ovl_addr),
      .row_addr   (ev_row_addr),
      .col_addr   (ev_col_addr),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .done       (ev_done)
   );

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside evaluation");
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_CLEAR) |-> !s1_valid_ff)
      else $error("accumulate write during clear");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.op == OP_EVAL)) |=> busy && eval_go_ff)
      else $error("evaluate not started");
`endif

endmodule

`default_nettype wire

/* tb/tb_label_overlap_detection.sv */
// testbench for label_overlap_detection: directed table, then random voxel streams
// under several threshold settings, checked against a local overlap predictor
// depends on lod_pkg and the label_overlap_detection rtl
`timescale 1ns / 1ps

module tb_label_overlap_detection;
   import lod_pkg::*;

   localparam int  NUM_LABELS = 64;
   localparam int  COUNT_MAX  = (1 << 24) - 1;
   localparam longint LIMIT   = 4000000;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type result;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_word_type               req_word = '0;
   logic                       rsp_strobe;
   rsp_word_type               rsp_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [THR_WIDTH-1:0]       csr_data = '0;

   int unsigned overlap[NUM_LABELS][NUM_LABELS];
   int unsigned row_sum[NUM_LABELS];
   int unsigned col_sum[NUM_LABELS];
   int unsigned top_ref, top_test;
   logic [THR_WIDTH-1:0] alpha_q, gamma_q, beta_q;

   rsp_word_type pending_q[$];
   bit           failed = 1'b0;
   bit           idle_on = 1'b1;
   longint       cycles = 0;
   int           max_label;

   label_overlap_detection i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_q.size() == 0) begin
            failed = 1'b1;
            $display("%0t unexpected word, expected none, actual %p", $time, rsp_word);
         end else begin
            if (rsp_word !== pending_q[0]) begin
               failed = 1'b1;
               $display("%0t mismatch expected %p actual %p", $time, pending_q[0], rsp_word);
            end
            void'(pending_q.pop_front());
         end
      end
   end

   function automatic void sat_inc(ref int unsigned c);
      if (c < COUNT_MAX) c = c + 1;
   endfunction

   function automatic void clear_counts();
      foreach (overlap[r, t]) overlap[r][t] = 0;
      foreach (row_sum[i]) row_sum[i] = 0;
      foreach (col_sum[i]) col_sum[i] = 0;
      top_ref = 0;
      top_test = 0;
   endfunction

   function automatic bit is_detected(int unsigned r);
      longint unsigned row, denom, acc, o0, tot;
      int unsigned order[$];
      int unsigned pos, t;
      row = row_sum[r];
      denom = longint'(overlap[r][0]) + row;
      acc = 0;
      if (row * 65536 <= longint'(alpha_q) * denom) return 1'b0;
      // descending overlap, ties kept in label order
      for (t = 1; t <= top_test; t++) begin
         pos = 0;
         while (pos < order.size() && overlap[r][order[pos]] >= overlap[r][t]) pos++;
         order.insert(pos, t);
      end
      pos = 0;
      while (acc * 65536 < longint'(gamma_q) * row) begin
         if (pos >= order.size()) break;
         t = order[pos];
         o0 = overlap[0][t];
         tot = o0 + col_sum[t];
         if (o0 * 65536 > longint'(beta_q) * tot) return 1'b0;
         acc += overlap[r][t];
         pos++;
      end
      return 1'b1;
   endfunction

   function automatic void predict_word(req_word_type w);
      rsp_word_type res;
      longint unsigned denom;
      if (w.op == OP_ACCUM) begin
         if (w.ref_label > top_ref) top_ref = w.ref_label;
         if (w.test_label > top_test) top_test = w.test_label;
         sat_inc(overlap[w.ref_label][w.test_label]);
         if (w.ref_label != 0 && w.test_label != 0) begin
            sat_inc(row_sum[w.ref_label]);
            sat_inc(col_sum[w.test_label]);
         end
         return;
      end
      if (top_ref == 0) begin
         res = '0;
         res.last = 1'b1;
         pending_q.push_back(res);
      end else begin
         for (int unsigned i = 1; i <= top_ref; i++) begin
            denom = longint'(overlap[i][0]) + row_sum[i];
            if (denom > COUNT_MAX) denom = COUNT_MAX;
            res.object_index = LABEL_WIDTH'(i);
            res.voxel_count = OUT_COUNT_WIDTH'(denom);
            res.detected = is_detected(i);
            res.last = (i == top_ref);
            pending_q.push_back(res);
         end
      end
      clear_counts();
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (pending_q.size() == 0 && !busy) break;
      end
      @(posedge clock);
   endtask

   task automatic send_word(req_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [THR_WIDTH-1:0] val);
      @(posedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      case (idx)
         CSR_ALPHA: alpha_q = val;
         CSR_GAMMA: gamma_q = val;
         default:   beta_q = val;
      endcase
   endtask

   function automatic req_word_type make_word(logic op, int r, int t);
      req_word_type w;
      w.op = op;
      w.ref_label = LABEL_WIDTH'(r);
      w.test_label = LABEL_WIDTH'(t);
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(int idx, int cnt, bit det, bit lst);
      rsp_word_type res;
      res.object_index = LABEL_WIDTH'(idx);
      res.voxel_count = OUT_COUNT_WIDTH'(cnt);
      res.detected = det;
      res.last = lst;
      return res;
   endfunction

   task automatic run_table();
      stim_row_type rows[$];
      int mark;
      rows.push_back('{make_word(OP_EVAL, 0, 0), 1, make_rsp(0, 0, 0, 1)});
      repeat (3) rows.push_back('{make_word(OP_ACCUM, 1, 1), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 1, 0), 0, '0});
      rows.push_back('{make_word(OP_EVAL, 0, 0), 1, make_rsp(1, 4, 1, 1)});
      // outside-dominated test object vetoes
      rows.push_back('{make_word(OP_ACCUM, 2, 5), 0, '0});
      repeat (3) rows.push_back('{make_word(OP_ACCUM, 0, 5), 0, '0});
      rows.push_back('{make_word(OP_EVAL, 63, 63), 0, '0});
      // extremes, empty objects below the top label, overlap ties
      rows.push_back('{make_word(OP_ACCUM, 63, 63), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 63, 62), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 63, 0), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 0, 63), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 0, 0), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 42, 21), 0, '0});
      rows.push_back('{make_word(OP_ACCUM, 21, 42), 0, '0});
      rows.push_back('{make_word(OP_EVAL, 0, 0), 0, '0});
      // background only leaves no reference objects
      rows.push_back('{make_word(OP_ACCUM, 0, 7), 0, '0});
      rows.push_back('{make_word(OP_EVAL, 0, 0), 1, make_rsp(0, 0, 0, 1)});
      foreach (rows[i]) begin
         send_word(rows[i].word);
         mark = pending_q.size();
         predict_word(rows[i].word);
         if (rows[i].typed) begin
            while (pending_q.size() > mark) void'(pending_q.pop_back());
            pending_q.push_back(rows[i].result);
         end
      end
   endtask

   initial begin
      logic [THR_WIDTH-1:0] settings[6][3];
      req_word_type w;
      int r, t, focus;
      alpha_q = ALPHA_RESET;
      gamma_q = GAMMA_RESET;
      beta_q  = BETA_RESET;
      clear_counts();
      settings = '{'{ALPHA_RESET, GAMMA_RESET, BETA_RESET},
                   '{17'd0, 17'd0, 17'd0},
                   '{17'd65536, 17'd65536, 17'd65536},
                   '{17'd0, 17'd65536, 17'd32768},
                   '{17'd0, 17'd0, 17'd0},
                   '{17'd0, 17'd0, 17'd0}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_drained();
      run_table();
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         if (phase == 4)
            for (int k = 0; k < 3; k++)
               settings[phase][k] = THR_WIDTH'($urandom_range(0, 65536));
         if (phase == 5) begin
            settings[phase][0] = THR_WIDTH'($urandom_range(0, 16384));
            settings[phase][1] = THR_WIDTH'($urandom_range(32768, 65536));
            settings[phase][2] = THR_WIDTH'($urandom_range(32768, 65535));
            idle_on = 1'b0;
         end
         write_csr(CSR_ALPHA, settings[phase][0]);
         write_csr(CSR_GAMMA, settings[phase][1]);
         write_csr(CSR_BETA, settings[phase][2]);
         for (int k = 0; k < 17; k++) begin
            max_label = (phase == 2 && k < 10) ? 63 : 7;
            if (phase == 3 && k == 10) wait_drained();
            focus = $urandom_range(1, max_label);
            if (k == 16 || $urandom_range(0, 11) == 0) begin
               w = make_word(OP_EVAL, $urandom_range(0, 63), $urandom_range(0, 63));
            end else begin
               // mostly one dominant object pair, some noise
               r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_label) : focus;
               t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, max_label)
                                               : (focus % max_label) + 1;
               w = make_word(OP_ACCUM, r, t);
            end
            send_word(w);
            predict_word(w);
         end
      end
      wait_drained();
      repeat (50) @(posedge clock);
      if (pending_q.size() != 0) failed = 1'b1;
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
